// ===== src/lss_pkg.sv =====
// Shared types and constants for the latency sample statistics block.
package lss_pkg;

	// Width of every sample and result field on the streams
	localparam int unsigned FIELD_W = 16;

	// Configuration register file
	localparam int unsigned PADDR_W         = 3;
	localparam int unsigned PDATA_W         = 32;
	localparam int unsigned NUM_SAMPLES_W   = 11;
	localparam logic [NUM_SAMPLES_W-1:0] NUM_SAMPLES_RST = 11'd1;

	// Register index taken from the word address bit
	localparam logic REG_NUM_SAMPLES = 1'b0;

	// One result item; first member sits in the highest bits
	typedef struct packed {
		logic [FIELD_W-1:0] std_dev;
		logic [FIELD_W-1:0] mean_value;
		logic [FIELD_W-1:0] max_value;
		logic [FIELD_W-1:0] min_value;
	} result_t;

endpackage

// ===== src/latency_sample_statistics.sv =====
// Top level: batch min / max / mean / standard deviation of latency samples.
//
//  channel   dir  handshake                  payload
//  s_axis    in   tvalid / tready            tdata[15:0] sample
//  m_axis    out  tvalid / tready            tdata[63:0] min, max, mean, std_dev
//  apb       in   psel / penable / pready    reg 0 num_samples at byte address 0
//
// An ordinary sample passes through two states: accept (square it, update min,
// max, sum and count) and accumulate the square. The sample that closes a batch
// then runs a shared restoring divider, one quotient bit per cycle, twice over
// the width of the sum of squares (SQW quotient bits each, 43 at the defaults),
// one state each to square the mean and form the variance, and SAMPLE_BITS
// steps of bit-pair square root. The finished result sits in an output
// register, so new samples are taken while it waits; only a second result
// waits for the first to be taken.
// Reset clears the accumulators and sets num_samples to one.
module latency_sample_statistics #(
	parameter int unsigned MAX_SAMPLES = 1024,
	parameter int unsigned SAMPLE_BITS = 16
) (
	input  logic                             clk,
	input  logic                             arst_n,
	// sample stream
	input  logic                             s_axis_tvalid,
	output logic                             s_axis_tready,
	input  logic [lss_pkg::FIELD_W-1:0]      s_axis_tdata,  // [15:0] sample
	// result stream
	output logic                             m_axis_tvalid,
	input  logic                             m_axis_tready,
	output logic [4*lss_pkg::FIELD_W-1:0]    m_axis_tdata,  // [15:0] min_value, [31:16] max_value,
	                                                        // [47:32] mean_value, [63:48] std_dev
	// configuration
	input  logic                             psel,
	input  logic                             penable,
	input  logic                             pwrite,
	input  logic [lss_pkg::PADDR_W-1:0]      paddr,
	input  logic [lss_pkg::PDATA_W-1:0]      pwdata,
	output logic [lss_pkg::PDATA_W-1:0]      prdata,
	output logic                             pready
);

	localparam int unsigned SB   = SAMPLE_BITS;
	localparam int unsigned CNTW = $clog2(MAX_SAMPLES + 1);
	localparam int unsigned SUMW = SB + CNTW;
	localparam int unsigned SQW  = 2 * SB + CNTW;
	localparam int unsigned STW  = (SQW > 1) ? $clog2(SQW) : 1;
	localparam int unsigned RW   = 2 * SB;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ACC,
		ST_DIV_SUM,
		ST_DIV_SQ,
		ST_SQUARE,
		ST_VAR,
		ST_SQRT,
		ST_DONE
	} state_t;

	state_t state_q;

	// Configuration
	logic [lss_pkg::NUM_SAMPLES_W-1:0] num_samples_q;

	// Accumulators
	logic [SB-1:0]   min_q;
	logic [SB-1:0]   max_q;
	logic [SUMW-1:0] sum_q;
	logic [SQW-1:0]  sumsq_q;
	logic [CNTW-1:0] cnt_q;
	logic [RW-1:0]   sq_s1;

	// Divider
	logic [SQW-1:0]  dq_q;
	logic [CNTW-1:0] rem_q;
	logic [STW-1:0]  step_q;

	// Finishing datapath
	logic [SB-1:0]   mean_q;
	logic [RW-1:0]   msq_q;
	logic [RW-1:0]   meansq_q;
	logic [RW-1:0]   rad_q;
	logic [RW-1:0]   root_q;
	logic [RW-1:0]   bit_q;

	lss_pkg::result_t res_q;
	logic             out_valid_q;

	logic [SB-1:0]   smp;
	logic            accept;
	logic            cfg_wr;
	logic [31:0]     batch;
	logic            batch_done;
	logic [CNTW:0]   rem_sh;
	logic            qbit;
	logic [CNTW:0]   rem_nx;
	logic [SQW-1:0]  q_nx;
	logic            div_last;
	logic [RW-1:0]   trial;
	logic [RW:0]     trial_up;
	logic            out_take;
	logic            res_load;

	// Upper sample bits beyond SAMPLE_BITS are ignored
	assign smp    = s_axis_tdata[SB-1:0];
	assign accept = s_axis_tvalid && s_axis_tready;
	assign cfg_wr = psel && penable && pwrite && pready;

	assign s_axis_tready = (state_q == ST_IDLE);
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = res_q;
	assign out_take      = out_valid_q && m_axis_tready;
	// Load the output register once it is empty or being emptied
	assign res_load      = (state_q == ST_DONE) && (!out_valid_q || m_axis_tready);

	assign pready = 1'b1;
	assign prdata = (paddr[2] == lss_pkg::REG_NUM_SAMPLES) ?
		lss_pkg::PDATA_W'(num_samples_q) : '0;

	// Effective batch size: zero acts as one, large values saturate
	always_comb begin
		batch = 32'(num_samples_q);
		if (batch == 32'd0) begin
			batch = 32'd1;
		end
		if (batch > 32'(MAX_SAMPLES)) begin
			batch = 32'(MAX_SAMPLES);
		end
	end
	assign batch_done = (32'(cnt_q) >= batch);

	// Restoring divide step: bring down one dividend bit, subtract if it fits
	assign rem_sh   = {rem_q, dq_q[SQW-1]};
	assign qbit     = (rem_sh >= {1'b0, cnt_q});
	assign rem_nx   = qbit ? (rem_sh - {1'b0, cnt_q}) : rem_sh;
	assign q_nx     = {dq_q[SQW-2:0], qbit};
	assign div_last = (step_q == STW'(SQW - 1));

	// Bit-pair square root step
	assign trial    = root_q + bit_q;
	assign trial_up = {1'b0, trial} + {1'b0, bit_q};

	// Configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_samples_q <= lss_pkg::NUM_SAMPLES_RST;
		end else if (cfg_wr && (paddr[2] == lss_pkg::REG_NUM_SAMPLES)) begin
			num_samples_q <= pwdata[lss_pkg::NUM_SAMPLES_W-1:0];
		end
	end

	// Sequencer, accumulators and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			min_q       <= '1;
			max_q       <= '0;
			sum_q       <= '0;
			sumsq_q     <= '0;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			// Drop valid once the waiting result is taken and nothing replaces it
			if (out_take && !res_load) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						// Square the sample; fold everything else in now
						sq_s1 <= RW'(smp) * RW'(smp);
						if (smp < min_q) begin
							min_q <= smp;
						end
						if (smp > max_q) begin
							max_q <= smp;
						end
						sum_q   <= sum_q + SUMW'(smp);
						cnt_q   <= cnt_q + CNTW'(1);
						state_q <= ST_ACC;
					end
				end
				ST_ACC: begin
					sumsq_q <= sumsq_q + SQW'(sq_s1);
					if (batch_done) begin
						// Batch closes: divide the sum first
						dq_q    <= SQW'(sum_q);
						rem_q   <= '0;
						step_q  <= '0;
						state_q <= ST_DIV_SUM;
					end else begin
						state_q <= ST_IDLE;
					end
				end
				ST_DIV_SUM: begin
					if (div_last) begin
						mean_q  <= q_nx[SB-1:0];
						dq_q    <= sumsq_q;
						rem_q   <= '0;
						step_q  <= '0;
						state_q <= ST_DIV_SQ;
					end else begin
						dq_q   <= q_nx;
						rem_q  <= rem_nx[CNTW-1:0];
						step_q <= step_q + STW'(1);
					end
				end
				ST_DIV_SQ: begin
					dq_q   <= q_nx;
					rem_q  <= rem_nx[CNTW-1:0];
					step_q <= step_q + STW'(1);
					if (div_last) begin
						msq_q   <= q_nx[RW-1:0];
						state_q <= ST_SQUARE;
					end
				end
				ST_SQUARE: begin
					meansq_q <= RW'(mean_q) * RW'(mean_q);
					state_q  <= ST_VAR;
				end
				ST_VAR: begin
					// Clamp at zero, then start the root from the top bit pair
					rad_q   <= (msq_q >= meansq_q) ? (msq_q - meansq_q) : '0;
					root_q  <= '0;
					bit_q   <= RW'(1) << (RW - 2);
					state_q <= ST_SQRT;
				end
				ST_SQRT: begin
					if (rad_q >= trial) begin
						rad_q  <= rad_q - trial;
						root_q <= trial_up[RW:1];
					end else begin
						root_q <= root_q >> 1;
					end
					bit_q <= bit_q >> 2;
					if (bit_q[0]) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					// Hold until the output register is free, then clear the batch
					if (res_load) begin
						res_q.min_value  <= lss_pkg::FIELD_W'(min_q);
						res_q.max_value  <= lss_pkg::FIELD_W'(max_q);
						res_q.mean_value <= lss_pkg::FIELD_W'(mean_q);
						res_q.std_dev    <= lss_pkg::FIELD_W'(root_q);
						out_valid_q      <= 1'b1;
						min_q            <= '1;
						max_q            <= '0;
						sum_q            <= '0;
						sumsq_q          <= '0;
						cnt_q            <= '0;
						state_q          <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

`ifndef ASSERT_OFF
	// The sample count never runs past the largest batch
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		32'(cnt_q) <= 32'(MAX_SAMPLES))
		else $error("sample count beyond MAX_SAMPLES");

	// A fresh result always comes with cleared accumulators
	a_clear_on_result: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_axis_tvalid) |-> (cnt_q == '0 && sum_q == '0 && sumsq_q == '0))
		else $error("accumulators not cleared with result");

	// The mean lies between the minimum and maximum of its batch
	a_mean_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (res_q.min_value <= res_q.mean_value &&
			res_q.mean_value <= res_q.max_value))
		else $error("mean outside min/max");

	// The root's trial bit stays a single bit while it iterates
	a_sqrt_bit: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SQRT) |-> $onehot(bit_q))
		else $error("square root trial bit corrupted");
`endif

endmodule
